// ===== sv/planar_pose_pid_deadband_defines.svh =====
// Assertion macros shared by the pose controller RTL.
`ifndef PLANAR_POSE_PID_DEADBAND_DEFINES_SVH
`define PLANAR_POSE_PID_DEADBAND_DEFINES_SVH

// Same-cycle implication.
`define PPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ppd_pkg.sv =====
// Types, constants and helper functions of the pose controller.
package ppd_pkg;

  localparam int DERIV_N = 26;  // bits of |error - previous error|
  localparam int DIV_W   = DERIV_N;  // divider dividend / quotient width
  localparam int CNT_W   = $clog2(DIV_W + 1);
  localparam int XY_DIV  = 15;
  localparam int W_DIV   = 30;
  localparam int HALF_TURN = 1800;
  localparam int FULL_TURN = 3600;

  // Divide by 15 through a reciprocal: exact for magnitudes below 2^19.
  // Anything at or above 15 * 32768 lands past every limit, so it is capped.
  localparam logic [59:0] Q_CAP    = 60'd491520;
  localparam logic [19:0] RECIP15  = 20'd559241;  // ceil(2^23 / 15)
  localparam int          RECIP_SH = 23;
  localparam logic [15:0] Q_SAT    = 16'h8000;

  localparam logic signed [24:0] BIG_ERR_E  = 25'sd100;
  localparam logic signed [24:0] BAND_ERR_E = 25'sd30;
  localparam logic [59:0]        BAND_VEL_M = 60'd10;

  localparam logic signed [47:0] INTEG_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] INTEG_MIN = {1'b1, {47{1'b0}}};

  typedef enum logic [2:0] {
    REG_KP_XY     = 3'd0,
    REG_KI_XY     = 3'd1,
    REG_KP_W      = 3'd2,
    REG_TIME_STEP = 3'd3,
    REG_XY_LIMIT  = 3'd4,
    REG_W_LIMIT   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [9:0]  kp_xy;
    logic [9:0]  ki_xy;
    logic [9:0]  kp_w;
    logic [7:0]  time_step;
    logic [14:0] xy_limit;
    logic [14:0] w_limit;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DSTART, S_DWAIT, S_MULTS, S_ACC, S_MULP, S_ADDD, S_MULI, S_ADDI,
    S_SSTART, S_SWAIT, S_WMUL, S_WSTART, S_WWAIT, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DSTART, OP_DWAIT, OP_MULTS, OP_ACC, OP_MULP, OP_ADDD,
    OP_MULI, OP_ADDI, OP_SSTART, OP_SWAIT, OP_WMUL, OP_WSTART, OP_WWAIT, OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic axis;  // 0: x, 1: y
  } cmd_t;

  // Dead band / big-error select, then clamp to +-lim.
  function automatic logic signed [15:0] vel_out(input logic [59:0] q,
                                                 input logic qneg,
                                                 input logic signed [24:0] err,
                                                 input logic [14:0] lim);
    logic [59:0] mag;
    logic        neg;
    logic [14:0] m15;
    if (err > BIG_ERR_E || err < -BIG_ERR_E) begin
      mag = q;
      neg = qneg;
    end else if (err > BAND_ERR_E) begin
      mag = BAND_VEL_M;
      neg = 1'b0;
    end else if (err < -BAND_ERR_E) begin
      mag = BAND_VEL_M;
      neg = 1'b1;
    end else begin
      mag = '0;
      neg = 1'b0;
    end
    if (mag > {45'd0, lim}) m15 = lim;
    else m15 = mag[14:0];
    return neg ? -$signed({1'b0, m15}) : $signed({1'b0, m15});
  endfunction

endpackage

// ===== sv/ppd_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, 8-bit divisor.
module ppd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppd_pkg::DIV_W-1:0]     dividend,
  input  logic [7:0]                    divisor,
  input  logic [ppd_pkg::CNT_W-1:0]     count,
  output logic                          done,
  output logic [ppd_pkg::DIV_W-1:0]     quotient
);

  logic                          busy;
  logic [ppd_pkg::CNT_W-1:0]     cnt;
  logic [ppd_pkg::DIV_W-1:0]     shreg;
  logic [7:0]                    rem;
  logic [7:0]                    dvs;
  logic [8:0]                    trial;
  logic [8:0]                    diff9;
  logic                          ge;
  logic [7:0]                    rem_next;

  assign trial    = {rem, shreg[ppd_pkg::DIV_W-1]};
  assign diff9    = trial - {1'b0, dvs};
  assign ge       = (trial >= {1'b0, dvs});
  assign rem_next = ge ? diff9[7:0] : trial[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= count;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ppd_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg    <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      shreg    <= {shreg[ppd_pkg::DIV_W-2:0], 1'b0};
      rem      <= rem_next;
      quotient <= {quotient[ppd_pkg::DIV_W-2:0], ge};
    end
  end

endmodule

// ===== sv/ppd_dp.sv =====
// Datapath: errors, integrals, products, shared divider, result registers.
module ppd_dp (
  input  logic                clk,
  input  logic                rst,
  input  ppd_pkg::cmd_t       cmd,
  input  ppd_pkg::cfg_t       cfg,
  input  logic signed [23:0]  target_x,
  input  logic signed [23:0]  target_y,
  input  logic [11:0]         target_angle,
  input  logic signed [23:0]  pos_x,
  input  logic signed [23:0]  pos_y,
  input  logic [11:0]         pos_angle,
  input  logic                drive_enable,
  output logic                div_done,
  output logic signed [15:0]  vel_x,
  output logic signed [15:0]  vel_y,
  output logic signed [15:0]  vel_w,
  output logic                drive_valid,
  output logic signed [24:0]  err_x,
  output logic signed [24:0]  err_y,
  output logic signed [11:0]  err_w,
  output logic                target_changed,
  output logic [7:0]          change_count
);

  localparam logic signed [13:0] HALF14 = 14'(ppd_pkg::HALF_TURN);
  localparam logic signed [13:0] FULL14 = 14'(ppd_pkg::FULL_TURN);

  // persistent state
  logic signed [24:0] prev_x, prev_y;
  logic signed [47:0] integ_x, integ_y;
  logic [23:0]        last_tx, last_ty;
  logic [11:0]        last_ta;
  logic [7:0]         chg_cnt;

  // per-item work registers
  logic signed [24:0] errx_r, erry_r;
  logic signed [11:0] errw_r;
  logic               en_r, chg_r;
  logic signed [25:0] deriv_r;
  logic               dneg_r, sneg_r;
  logic signed [58:0] mul_r;
  logic signed [47:0] acc_r;
  logic signed [59:0] sum_r;
  logic signed [15:0] vx_r, vy_r, vw_r;
  logic [18:0]        qx_r;
  logic               qbig_r;

  logic [7:0]         ts_eff;
  logic signed [24:0] err_a, prev_a;
  logic signed [47:0] integ_a;
  logic signed [24:0] ex_c, ey_c;
  logic signed [13:0] ew_raw, ew_wrap;
  logic               chg_c;
  logic signed [25:0] diff;
  logic [25:0]        dmag;
  logic [59:0]        smag;
  logic [59:0]        qsrc;
  logic               qbig;
  logic [38:0]        qprod;
  logic [15:0]        qc;
  logic signed [33:0] prod_ts;
  logic signed [48:0] sumi;
  logic signed [47:0] sat;
  logic signed [35:0] prod_p;
  logic signed [29:0] d30, dten;
  logic signed [58:0] prod_i;
  logic signed [22:0] prod_w;
  logic [25:0]        dq;
  logic signed [15:0] v_axis, v_w;

  logic                           div_start;
  logic [ppd_pkg::DIV_W-1:0]      quo;

  assign ts_eff  = (cfg.time_step == 8'd0) ? 8'd1 : cfg.time_step;
  assign err_a   = cmd.axis ? erry_r : errx_r;
  assign prev_a  = cmd.axis ? prev_y : prev_x;
  assign integ_a = cmd.axis ? integ_y : integ_x;

  assign ex_c   = {target_x[23], target_x} - {pos_x[23], pos_x};
  assign ey_c   = {target_y[23], target_y} - {pos_y[23], pos_y};
  assign ew_raw = $signed({2'b00, target_angle}) - $signed({2'b00, pos_angle});
  assign chg_c  = (target_x != last_tx) || (target_y != last_ty) ||
                  (target_angle != last_ta);

  always_comb begin
    if (ew_raw > HALF14) ew_wrap = ew_raw - FULL14;
    else if (ew_raw < -HALF14) ew_wrap = ew_raw + FULL14;
    else ew_wrap = ew_raw;
  end

  assign diff = {err_a[24], err_a} - {prev_a[24], prev_a};
  assign dmag = diff[25] ? (~diff + 26'd1) : diff;
  assign smag = sum_r[59] ? (~sum_r + 60'd1) : sum_r;

  // heading: x / 30 == (x / 2) / 15
  assign qsrc  = (cmd.op == ppd_pkg::OP_WSTART) ? {1'b0, smag[59:1]} : smag;
  assign qbig  = (qsrc >= ppd_pkg::Q_CAP);
  assign qprod = qx_r * ppd_pkg::RECIP15;
  assign qc    = qbig_r ? ppd_pkg::Q_SAT : qprod[ppd_pkg::RECIP_SH +: 16];

  assign prod_ts = err_a * $signed({1'b0, ts_eff});
  assign sumi    = {integ_a[47], integ_a} + mul_r[48:0];
  always_comb begin
    if (sumi[48] != sumi[47]) sat = sumi[48] ? ppd_pkg::INTEG_MIN : ppd_pkg::INTEG_MAX;
    else sat = sumi[47:0];
  end

  assign prod_p = err_a * $signed({1'b0, cfg.kp_xy});
  assign d30    = {{4{deriv_r[25]}}, deriv_r};
  assign dten   = (d30 <<< 3) + (d30 <<< 1);
  assign prod_i = acc_r * $signed({1'b0, cfg.ki_xy});
  assign prod_w = errw_r * $signed({1'b0, cfg.kp_w});
  assign dq     = quo;

  assign v_axis = ppd_pkg::vel_out({44'd0, qc}, sneg_r, err_a, cfg.xy_limit);
  assign v_w    = ppd_pkg::vel_out({44'd0, qc}, sneg_r, {{13{errw_r[11]}}, errw_r},
                                   cfg.w_limit);

  assign div_start = (cmd.op == ppd_pkg::OP_DSTART);

  ppd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dmag),
    .divisor  (ts_eff),
    .count    (ppd_pkg::CNT_W'(ppd_pkg::DERIV_N)),
    .done     (div_done),
    .quotient (quo)
  );

  // model state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x  <= '0;
      prev_y  <= '0;
      integ_x <= '0;
      integ_y <= '0;
      last_tx <= '0;
      last_ty <= '0;
      last_ta <= '0;
      chg_cnt <= '0;
    end else begin
      if (cmd.op == ppd_pkg::OP_LOAD) begin
        last_tx <= target_x;
        last_ty <= target_y;
        last_ta <= target_angle;
        if (chg_c) chg_cnt <= chg_cnt + 8'd1;
      end
      if (cmd.op == ppd_pkg::OP_ACC) begin
        if (cmd.axis) begin
          integ_y <= sat;
          prev_y  <= err_a;
        end else begin
          integ_x <= sat;
          prev_x  <= err_a;
        end
      end
    end
  end

  // work and result registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ppd_pkg::OP_LOAD: begin
        errx_r <= ex_c;
        erry_r <= ey_c;
        errw_r <= ew_wrap[11:0];
        en_r   <= drive_enable;
        chg_r  <= chg_c;
      end
      ppd_pkg::OP_DSTART: dneg_r <= diff[25];
      ppd_pkg::OP_DWAIT: begin
        if (div_done) deriv_r <= dneg_r ? -$signed(dq) : $signed(dq);
      end
      ppd_pkg::OP_MULTS: mul_r <= {{25{prod_ts[33]}}, prod_ts};
      ppd_pkg::OP_ACC:   acc_r <= sat;
      ppd_pkg::OP_MULP:  sum_r <= {{24{prod_p[35]}}, prod_p};
      ppd_pkg::OP_ADDD:  sum_r <= sum_r + {{30{dten[29]}}, dten};
      ppd_pkg::OP_MULI:  mul_r <= prod_i;
      ppd_pkg::OP_ADDI:  sum_r <= sum_r + {mul_r[58], mul_r};
      ppd_pkg::OP_SSTART, ppd_pkg::OP_WSTART: begin
        sneg_r <= sum_r[59];
        qx_r   <= qsrc[18:0];
        qbig_r <= qbig;
      end
      ppd_pkg::OP_SWAIT: begin
        if (cmd.axis) vy_r <= v_axis;
        else vx_r <= v_axis;
      end
      ppd_pkg::OP_WMUL:  sum_r <= {{37{prod_w[22]}}, prod_w};
      ppd_pkg::OP_WWAIT: vw_r <= v_w;
      ppd_pkg::OP_COMMIT: begin
        vel_x          <= vx_r;
        vel_y          <= vy_r;
        vel_w          <= vw_r;
        drive_valid    <= en_r;
        err_x          <= errx_r;
        err_y          <= erry_r;
        err_w          <= errw_r;
        target_changed <= chg_r;
        change_count   <= chg_cnt;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/ppd_ctrl.sv =====
// Controller: sequences the datapath and owns the handshake state.
module ppd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          div_done,
  output ppd_pkg::cmd_t cmd
);

  ppd_pkg::state_t state, state_next;
  logic            axis, axis_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ppd_pkg::S_IDLE;
      axis      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != ppd_pkg::S_IDLE);

  always_comb begin
    state_next     = state;
    axis_next      = axis;
    out_valid_next = out_valid && out_stall;
    cmd.op         = ppd_pkg::OP_NONE;
    cmd.axis       = axis;
    unique case (state)
      ppd_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op     = ppd_pkg::OP_LOAD;
          axis_next  = 1'b0;
          state_next = ppd_pkg::S_DSTART;
        end
      end
      ppd_pkg::S_DSTART: begin
        cmd.op     = ppd_pkg::OP_DSTART;
        state_next = ppd_pkg::S_DWAIT;
      end
      ppd_pkg::S_DWAIT: begin
        cmd.op = ppd_pkg::OP_DWAIT;
        if (div_done) state_next = ppd_pkg::S_MULTS;
      end
      ppd_pkg::S_MULTS: begin
        cmd.op     = ppd_pkg::OP_MULTS;
        state_next = ppd_pkg::S_ACC;
      end
      ppd_pkg::S_ACC: begin
        cmd.op     = ppd_pkg::OP_ACC;
        state_next = ppd_pkg::S_MULP;
      end
      ppd_pkg::S_MULP: begin
        cmd.op     = ppd_pkg::OP_MULP;
        state_next = ppd_pkg::S_ADDD;
      end
      ppd_pkg::S_ADDD: begin
        cmd.op     = ppd_pkg::OP_ADDD;
        state_next = ppd_pkg::S_MULI;
      end
      ppd_pkg::S_MULI: begin
        cmd.op     = ppd_pkg::OP_MULI;
        state_next = ppd_pkg::S_ADDI;
      end
      ppd_pkg::S_ADDI: begin
        cmd.op     = ppd_pkg::OP_ADDI;
        state_next = ppd_pkg::S_SSTART;
      end
      ppd_pkg::S_SSTART: begin
        cmd.op     = ppd_pkg::OP_SSTART;
        state_next = ppd_pkg::S_SWAIT;
      end
      ppd_pkg::S_SWAIT: begin
        cmd.op = ppd_pkg::OP_SWAIT;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = ppd_pkg::S_DSTART;
        end else begin
          state_next = ppd_pkg::S_WMUL;
        end
      end
      ppd_pkg::S_WMUL: begin
        cmd.op     = ppd_pkg::OP_WMUL;
        state_next = ppd_pkg::S_WSTART;
      end
      ppd_pkg::S_WSTART: begin
        cmd.op     = ppd_pkg::OP_WSTART;
        state_next = ppd_pkg::S_WWAIT;
      end
      ppd_pkg::S_WWAIT: begin
        cmd.op     = ppd_pkg::OP_WWAIT;
        state_next = ppd_pkg::S_DONE;
      end
      ppd_pkg::S_DONE: begin
        // output register free or being emptied this cycle
        if (!out_valid || !out_stall) begin
          cmd.op         = ppd_pkg::OP_COMMIT;
          out_valid_next = 1'b1;
          state_next     = ppd_pkg::S_IDLE;
        end
      end
      default: state_next = ppd_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== sv/planar_pose_pid_deadband.sv =====
// Top level of the planar pose PID controller with dead band.
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | target and measured pose, drive_enable
//   out     | output    | out_valid / out_stall | velocities, errors, change flag and count
//   config  | input     | wr_en                 | wr_index, wr_data
// The result is loaded after the x, y and heading passes, once the output register is
// free, and the next item can be accepted in the cycle after the load; each x and y
// pass holds the bit-serial derivative divide (26 steps over time_step).
// One item is in work at a time; in_stall is high from accept until the result
// is loaded into the output register, which holds it while out_stall is high.
// Synchronous reset clears the controller and loop state and loads the default config.
`include "planar_pose_pid_deadband_defines.svh"

module planar_pose_pid_deadband (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] target_x,
  input  logic signed [23:0] target_y,
  input  logic [11:0]        target_angle,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic [11:0]        pos_angle,
  input  logic               drive_enable,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] vel_x,
  output logic signed [15:0] vel_y,
  output logic signed [15:0] vel_w,
  output logic               drive_valid,
  output logic signed [24:0] err_x,
  output logic signed [24:0] err_y,
  output logic signed [11:0] err_w,
  output logic               target_changed,
  output logic [7:0]         change_count,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [14:0]        wr_data
);

  ppd_pkg::cfg_t cfg;
  ppd_pkg::cmd_t cmd;
  logic          div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_xy     <= 10'd1;
      cfg.ki_xy     <= 10'd1;
      cfg.kp_w      <= 10'd0;
      cfg.time_step <= 8'd1;
      cfg.xy_limit  <= 15'd100;
      cfg.w_limit   <= 15'd100;
    end else if (wr_en) begin
      unique case (ppd_pkg::reg_idx_t'(wr_index))
        ppd_pkg::REG_KP_XY:     cfg.kp_xy     <= wr_data[9:0];
        ppd_pkg::REG_KI_XY:     cfg.ki_xy     <= wr_data[9:0];
        ppd_pkg::REG_KP_W:      cfg.kp_w      <= wr_data[9:0];
        ppd_pkg::REG_TIME_STEP: cfg.time_step <= wr_data[7:0];
        ppd_pkg::REG_XY_LIMIT:  cfg.xy_limit  <= wr_data;
        ppd_pkg::REG_W_LIMIT:   cfg.w_limit   <= wr_data;
        default: ;
      endcase
    end
  end

  ppd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  ppd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .target_x       (target_x),
    .target_y       (target_y),
    .target_angle   (target_angle),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_angle      (pos_angle),
    .drive_enable   (drive_enable),
    .div_done       (div_done),
    .vel_x          (vel_x),
    .vel_y          (vel_y),
    .vel_w          (vel_w),
    .drive_valid    (drive_valid),
    .err_x          (err_x),
    .err_y          (err_y),
    .err_w          (err_w),
    .target_changed (target_changed),
    .change_count   (change_count)
  );

  `PPD_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "accepted item did not make the block busy")
  `PPD_ASSERT_NOW(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall), "result appeared with no item in work")
  `PPD_ASSERT_NOW(a_err_w_wrapped, clk, rst, out_valid, (err_w <= 12'sd1800) && (err_w >= -12'sd1800), "heading error out of range")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the planar pose PID controller with dead band.
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 300;

  typedef struct packed {
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic [11:0]        ta;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [11:0]        pa;
    logic               en;
  } pose_in_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_w;
    logic               drive_valid;
    logic signed [24:0] err_x;
    logic signed [24:0] err_y;
    logic signed [11:0] err_w;
    logic               target_changed;
    logic [7:0]         change_count;
  } pose_cmd_t;

  typedef struct {
    pose_in_t  item;
    logic      typed;
    pose_cmd_t cmd;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall, out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] target_x, target_y, pos_x, pos_y;
  logic [11:0] target_angle, pos_angle;
  logic drive_enable;
  logic signed [15:0] vel_x, vel_y, vel_w;
  logic drive_valid, target_changed;
  logic signed [24:0] err_x, err_y;
  logic signed [11:0] err_w;
  logic [7:0] change_count;
  logic wr_en;
  logic [2:0] wr_index;
  logic [14:0] wr_data;

  planar_pose_pid_deadband dut (.*);

  always #5 clk = ~clk;

  // controller model state
  longint kp_xy_m, ki_xy_m, kp_w_m, tstep_m, xy_lim_m, w_lim_m;
  longint prev_ex, prev_ey, integ_ex, integ_ey;
  logic [23:0] last_tx, last_ty;
  logic [11:0] last_ta;
  logic [7:0]  change_cnt_m;

  pose_cmd_t expected_cmds[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  pose_in_t  last_item;
  stim_row_t rows[$];

  function automatic longint clamp_vel(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint dead_band(longint e);
    if (e > 30) return 10;
    if (e < -30) return -10;
    return 0;
  endfunction

  function automatic longint axis_vel(input longint e, inout longint prev,
                                      inout longint integ, input longint ts);
    longint deriv, acc, v;
    deriv = (e - prev) / ts;
    acc = integ + e * ts;
    if (acc > longint'(ppd_pkg::INTEG_MAX)) acc = longint'(ppd_pkg::INTEG_MAX);
    if (acc < longint'(ppd_pkg::INTEG_MIN)) acc = longint'(ppd_pkg::INTEG_MIN);
    integ = acc;
    prev = e;
    if (e > 100 || e < -100)
      v = (e * kp_xy_m + deriv * 10 + acc * ki_xy_m) / ppd_pkg::XY_DIV;
    else v = dead_band(e);
    return clamp_vel(v, xy_lim_m);
  endfunction

  function automatic pose_cmd_t predict_cmd(pose_in_t it);
    pose_cmd_t c;
    longint ts, ex, ey, ew, vw;
    ts = (tstep_m == 0) ? 1 : tstep_m;
    ex = longint'(it.tx) - longint'(it.px);
    ey = longint'(it.ty) - longint'(it.py);
    ew = longint'({1'b0, it.ta}) - longint'({1'b0, it.pa});
    c.target_changed = (it.tx != last_tx || it.ty != last_ty || it.ta != last_ta);
    if (c.target_changed) change_cnt_m = change_cnt_m + 8'd1;
    last_tx = it.tx; last_ty = it.ty; last_ta = it.ta;
    c.vel_x = 16'(axis_vel(ex, prev_ex, integ_ex, ts));
    c.vel_y = 16'(axis_vel(ey, prev_ey, integ_ey, ts));
    if (ew > ppd_pkg::HALF_TURN) ew -= ppd_pkg::FULL_TURN;
    else if (ew < -ppd_pkg::HALF_TURN) ew += ppd_pkg::FULL_TURN;
    if (ew > 100 || ew < -100) vw = ew * kp_w_m / ppd_pkg::W_DIV;
    else vw = dead_band(ew);
    c.vel_w = 16'(clamp_vel(vw, w_lim_m));
    c.drive_valid = it.en;
    c.err_x = 25'(ex);
    c.err_y = 25'(ey);
    c.err_w = 12'(ew);
    c.change_count = change_cnt_m;
    return c;
  endfunction

  task automatic write_reg(ppd_pkg::reg_idx_t idx, int unsigned val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= 15'(val);
    case (idx)
      ppd_pkg::REG_KP_XY:     kp_xy_m = val & 10'h3FF;
      ppd_pkg::REG_KI_XY:     ki_xy_m = val & 10'h3FF;
      ppd_pkg::REG_KP_W:      kp_w_m = val & 10'h3FF;
      ppd_pkg::REG_TIME_STEP: tstep_m = val & 8'hFF;
      ppd_pkg::REG_XY_LIMIT:  xy_lim_m = val & 15'h7FFF;
      ppd_pkg::REG_W_LIMIT:   w_lim_m = val & 15'h7FFF;
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // The block's state leaves idle on any accept, so dropping valid here
  // never lets a held item in twice.
  task automatic wait_drained();
    @(posedge clk);
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_config(int unsigned kp, int unsigned ki, int unsigned kpw,
                            int unsigned ts, int unsigned xyl, int unsigned wl);
    wait_drained();
    write_reg(ppd_pkg::REG_KP_XY, kp);
    write_reg(ppd_pkg::REG_KI_XY, ki);
    write_reg(ppd_pkg::REG_KP_W, kpw);
    write_reg(ppd_pkg::REG_TIME_STEP, ts);
    write_reg(ppd_pkg::REG_XY_LIMIT, xyl);
    write_reg(ppd_pkg::REG_W_LIMIT, wl);
  endtask

  int burst_left = 0;

  // Present one item, wait for accept, record its expected result, then at times pause with valid low.
  task automatic send_item(pose_in_t it, logic typed, pose_cmd_t typed_cmd);
    pose_cmd_t c;
    int gap;
    in_valid <= 1'b1;
    target_x <= it.tx; target_y <= it.ty; target_angle <= it.ta;
    pos_x <= it.px; pos_y <= it.py; pos_angle <= it.pa; drive_enable <= it.en;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    c = predict_cmd(it);
    expected_cmds.push_back(typed ? typed_cmd : c);
    last_item = it;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  function automatic pose_in_t rand_item();
    pose_in_t it;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 5 && $urandom_range(0, 2) != 0) begin
      it.tx = last_item.tx; it.ty = last_item.ty; it.ta = last_item.ta;
    end else if (kind < 7) begin
      it.tx = 24'($urandom); it.ty = 24'($urandom);
      it.ta = 12'($urandom_range(0, 3599));
    end else begin
      it.tx = 24'($signed($urandom_range(0, 65535)) - 32768);
      it.ty = 24'($signed($urandom_range(0, 65535)) - 32768);
      it.ta = 12'($urandom_range(0, 3599));
    end
    if (kind < 5) begin
      // errors around the dead band and the big-error threshold
      it.px = it.tx - 24'($signed($urandom_range(0, 300)) - 150);
      it.py = it.ty - 24'($signed($urandom_range(0, 300)) - 150);
      it.pa = 12'(int'(it.ta) + $urandom_range(0, 300) - 150);
      if (it.pa > 3599) it.pa = 12'($urandom_range(0, 3599));
    end else if (kind < 7) begin
      it.px = 24'($urandom); it.py = 24'($urandom);
      it.pa = 12'($urandom_range(0, 3599));
    end else begin
      it.px = 24'($signed($urandom_range(0, 65535)) - 32768);
      it.py = 24'($signed($urandom_range(0, 65535)) - 32768);
      it.pa = 12'($urandom_range(0, 3599));
    end
    // headings past 3599 now and then
    if ($urandom_range(0, 7) == 0) it.ta = 12'($urandom);
    if ($urandom_range(0, 7) == 0) it.pa = 12'($urandom);
    it.en = 1'($urandom);
    return it;
  endfunction

  function automatic stim_row_t row(logic signed [23:0] tx, ty, logic [11:0] ta,
                                    logic signed [23:0] px, py, logic [11:0] pa,
                                    logic en, logic typed, pose_cmd_t cmd);
    stim_row_t r;
    r.item = '{tx, ty, ta, px, py, pa, en};
    r.typed = typed;
    r.cmd = cmd;
    return r;
  endfunction

  task automatic chk(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, e, a);
      mismatches++;
    end
  endtask

  // receiver: stall pattern plus result checking
  int stall_mode = 0;
  int stall_span = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t mismatch unexpected item expected none actual vel_x %0d",
                 $time, vel_x);
        mismatches++;
      end else begin
        pose_cmd_t e;
        e = expected_cmds.pop_front();
        chk("vel_x", e.vel_x, vel_x);
        chk("vel_y", e.vel_y, vel_y);
        chk("vel_w", e.vel_w, vel_w);
        chk("drive_valid", e.drive_valid, drive_valid);
        chk("err_x", e.err_x, err_x);
        chk("err_y", e.err_y, err_y);
        chk("err_w", e.err_w, err_w);
        chk("target_changed", e.target_changed, target_changed);
        chk("change_count", e.change_count, change_count);
      end
    end
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_span = $urandom_range(1, 400);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    pose_cmd_t z;
    z = '0;
    rst <= 1'b1;
    in_valid <= 1'b0; wr_en <= 1'b0; wr_index <= '0; wr_data <= '0;
    target_x <= '0; target_y <= '0; target_angle <= '0;
    pos_x <= '0; pos_y <= '0; pos_angle <= '0; drive_enable <= 1'b0;
    kp_xy_m = 1; ki_xy_m = 1; kp_w_m = 0; tstep_m = 1; xy_lim_m = 100; w_lim_m = 100;
    prev_ex = 0; prev_ey = 0; integ_ex = 0; integ_ey = 0;
    last_tx = '0; last_ty = '0; last_ta = '0; change_cnt_m = '0;
    last_item = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first item after reset: zero target, zero errors
    rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 1, z));
    rows.push_back(row(100, 0, 0, 0, 0, 0, 1, 1,
                       '{16'sd10, 16'sd0, 16'sd0, 1'b1, 25'sd100, 25'sd0, 12'sd0, 1'b1, 8'd1}));
    rows.push_back(row(100, 0, 0, 131, 0, 0, 1, 1,
                       '{-16'sd10, 16'sd0, 16'sd0, 1'b1, -25'sd31, 25'sd0, 12'sd0, 1'b0, 8'd1}));
    rows.push_back(row(100, 0, 3599, 100, 0, 0, 0, 1,
                       '{16'sd0, 16'sd0, 16'sd0, 1'b0, 25'sd0, 25'sd0, -12'sd1, 1'b1, 8'd2}));
    // heading above 3599 still wraps once
    rows.push_back(row(100, 0, 0, 100, 0, 4095, 1, 1,
                       '{16'sd0, 16'sd0, 16'sd0, 1'b1, 25'sd0, 25'sd0, -12'sd495, 1'b1, 8'd3}));
    rows.push_back(row(24'sh7FFFFF, 24'sh800000, 1800, 24'sh800000, 24'sh7FFFFF, 0, 1, 0, z));
    rows.push_back(row(24'sh800000, 24'sh7FFFFF, 0, 24'sh7FFFFF, 24'sh800000, 1801, 0, 0, z));
    rows.push_back(row(24'sh800000, 24'sh7FFFFF, 0, 24'sh800000, 24'sh7FFFFF, 0, 1, 0, z));
    rows.push_back(row(30, -30, 130, 0, 0, 0, 1, 0, z));
    rows.push_back(row(101, -101, 0, 0, 0, 101, 1, 0, z));
    rows.push_back(row(-100, 100, 4095, 0, 0, 4095, 0, 0, z));
    rows.push_back(row(24'shFFFFFF, 24'sh000001, 3599, 24'sh000001, 24'shFFFFFF, 1799, 1, 0, z));
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].cmd);

    // extreme gains, zero time step, widest limits
    set_config(1023, 1023, 1023, 0, 32767, 32767);
    foreach (rows[i]) send_item(rows[i].item, 1'b0, z);
    // zero gains, longest time step, zero limits
    set_config(0, 0, 0, 255, 0, 0);
    repeat (12) send_item(rand_item(), 1'b0, z);

    for (int ph = 0; ph < 4; ph++) begin
      set_config($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 255), $urandom_range(0, 32767), $urandom_range(0, 32767));
      for (int n = 0; n < 190; n++) begin
        if (ph == 1 && n == 95) wait_drained();
        send_item(rand_item(), 1'b0, z);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== planar_pose_pid_deadband.f =====
+incdir+sv
sv/ppd_pkg.sv
sv/ppd_div.sv
sv/ppd_dp.sv
sv/ppd_ctrl.sv
sv/planar_pose_pid_deadband.sv
sim/testbench.sv
